// ===== src/mbbn_pkg.sv =====
package mbbn_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 32;
  localparam int OUT_W      = FRAC_BITS + 2;
  localparam int SCALE_W    = 32;
  localparam int NAXIS      = 3;

  localparam int EXT_W   = COORD_BITS;
  localparam int MAG_W   = COORD_BITS + 1;
  localparam int HI_W    = MAG_W - FRAC_BITS;
  localparam int MUL_A_W = (HI_W > FRAC_BITS) ? HI_W : FRAC_BITS;
  localparam int PP_W    = MUL_A_W + SCALE_W;
  localparam int SUM_W   = PP_W + 1;
  localparam int DIVD_W  = 2 * FRAC_BITS + 2;
  localparam int DCNT_W  = $clog2(DIVD_W);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [DIVD_W-1:0]       DIVIDEND = {1'b1, {(DIVD_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]        ONE_FIX  = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [OUT_W-1:0] ONE_OUT  = OUT_W'(1) << FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_ACC,
    CMD_FIN,
    CMD_NORM
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   seed;
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_FIN,
    BS_EMAX,
    BS_DIV,
    BS_DIFF,
    BS_LO,
    BS_HI,
    BS_SUM,
    BS_SAT
  } bstate_t;

endpackage

// ===== src/mbbn_front.sv =====
module mbbn_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                operation,
  input  logic signed [mbbn_pkg::POS_W-1:0]   pos_x,
  input  logic signed [mbbn_pkg::POS_W-1:0]   pos_y,
  input  logic signed [mbbn_pkg::POS_W-1:0]   pos_z,
  input  logic                                first_vertex,
  input  logic                                last_vertex,
  input  mbbn_pkg::qstat_t                    q_stat,
  output logic                                q_push,
  output mbbn_pkg::vtx_t                      q_word
);

  logic           slot_v_r, slot_v_nxt;
  mbbn_pkg::vtx_t slot_r, slot_nxt;
  logic           accept;

  assign full   = slot_v_r && q_stat.full;
  assign accept = push && !full;
  assign q_push = slot_v_r && !q_stat.full;
  assign q_word = slot_r;

  // classify the incoming word
  always_comb begin
    slot_nxt   = slot_r;
    slot_v_nxt = slot_v_r && !q_push;
    if (accept) begin
      slot_v_nxt    = 1'b1;
      slot_nxt.x    = pos_x[mbbn_pkg::COORD_BITS-1:0];
      slot_nxt.y    = pos_y[mbbn_pkg::COORD_BITS-1:0];
      slot_nxt.z    = pos_z[mbbn_pkg::COORD_BITS-1:0];
      slot_nxt.seed = first_vertex && !operation;
      if (operation) begin
        slot_nxt.cmd = mbbn_pkg::CMD_NORM;
      end else if (last_vertex) begin
        slot_nxt.cmd = mbbn_pkg::CMD_FIN;
      end else begin
        slot_nxt.cmd = mbbn_pkg::CMD_ACC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
    end else begin
      slot_v_r <= slot_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// ===== src/mbbn_fifo.sv =====
module mbbn_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbbn_pkg::vtx_t   wr_word,
  input  logic             pop,
  output mbbn_pkg::vtx_t   rd_word,
  output mbbn_pkg::qstat_t stat
);

  mbbn_pkg::vtx_t                mem_r [mbbn_pkg::QDEPTH];
  logic [mbbn_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mbbn_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mbbn_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == mbbn_pkg::QCNT_W'(mbbn_pkg::QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_word    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mbbn_pkg::QPTR_W'(mbbn_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mbbn_pkg::QPTR_W'(mbbn_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

// ===== src/mbbn_back.sv =====
module mbbn_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mbbn_pkg::qstat_t                    q_stat,
  input  mbbn_pkg::vtx_t                      q_word,
  output logic                                q_pop,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic signed [mbbn_pkg::OUT_W-1:0]   out_norm_x,
  output logic signed [mbbn_pkg::OUT_W-1:0]   out_norm_y,
  output logic signed [mbbn_pkg::OUT_W-1:0]   out_norm_z,
  output logic                                out_degenerate
);

  localparam int F = mbbn_pkg::FRAC_BITS;
  localparam int N = mbbn_pkg::NAXIS;

  mbbn_pkg::bstate_t state_r, state_nxt;

  mbbn_pkg::coord_t min_r [N];
  mbbn_pkg::coord_t min_nxt [N];
  mbbn_pkg::coord_t max_r [N];
  mbbn_pkg::coord_t max_nxt [N];
  mbbn_pkg::coord_t center_r [N];
  mbbn_pkg::coord_t center_nxt [N];
  logic [mbbn_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic                         zero_r, zero_nxt;

  logic [mbbn_pkg::EXT_W-1:0]  ext_r [N];
  logic [mbbn_pkg::EXT_W-1:0]  ext_nxt [N];
  logic [mbbn_pkg::EXT_W-1:0]  div_r, div_nxt;
  logic [mbbn_pkg::EXT_W-1:0]  rem_r, rem_nxt;
  logic [mbbn_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [mbbn_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;

  mbbn_pkg::coord_t            pos_r [N];
  mbbn_pkg::coord_t            pos_nxt [N];
  logic [mbbn_pkg::MAG_W-1:0]  mag_r [N];
  logic [mbbn_pkg::MAG_W-1:0]  mag_nxt [N];
  logic                        neg_r [N];
  logic                        neg_nxt [N];
  logic [mbbn_pkg::PP_W-1:0]   lo_r [N];
  logic [mbbn_pkg::PP_W-1:0]   lo_nxt [N];
  logic [mbbn_pkg::PP_W-1:0]   hi_r [N];
  logic [mbbn_pkg::PP_W-1:0]   hi_nxt [N];
  logic [mbbn_pkg::SUM_W-1:0]  sum_r [N];
  logic [mbbn_pkg::SUM_W-1:0]  sum_nxt [N];

  logic                         out_v_r, out_v_nxt;
  logic [mbbn_pkg::OUT_W-1:0]   out_r [N];
  logic [mbbn_pkg::OUT_W-1:0]   out_nxt [N];
  logic                         deg_r, deg_nxt;

  mbbn_pkg::coord_t               vin [N];
  logic                           slot_free;
  logic [mbbn_pkg::MUL_A_W-1:0]   mul_a [N];
  logic [mbbn_pkg::PP_W-1:0]      mul_p [N];
  logic [mbbn_pkg::COORD_BITS:0]  wide_diff [N];
  logic [mbbn_pkg::COORD_BITS:0]  wide_sum [N];
  logic [mbbn_pkg::MAG_W-1:0]     d [N];
  logic [mbbn_pkg::EXT_W-1:0]     emax;
  logic [mbbn_pkg::EXT_W:0]       rem_sh;
  logic [mbbn_pkg::SUM_W-1:0]     sat [N];
  logic [mbbn_pkg::OUT_W-1:0]     rmag [N];

  assign vin[0]    = q_word.x;
  assign vin[1]    = q_word.y;
  assign vin[2]    = q_word.z;
  assign slot_free = !out_v_r || out_pop;

  assign out_empty      = !out_v_r;
  assign out_norm_x     = out_r[0];
  assign out_norm_y     = out_r[1];
  assign out_norm_z     = out_r[2];
  assign out_degenerate = deg_r;

  // one multiplier per lane, low then high half of the magnitude
  always_comb begin
    for (int a = 0; a < N; a++) begin
      if (state_r == mbbn_pkg::BS_LO) begin
        mul_a[a] = mbbn_pkg::MUL_A_W'(mag_r[a][F-1:0]);
      end else begin
        mul_a[a] = mbbn_pkg::MUL_A_W'(mag_r[a][mbbn_pkg::MAG_W-1:F]);
      end
      mul_p[a] = mbbn_pkg::PP_W'(mul_a[a]) * mbbn_pkg::PP_W'(scale_r);
    end
  end

  always_comb begin
    for (int a = 0; a < N; a++) begin
      wide_diff[a] = {max_r[a][mbbn_pkg::COORD_BITS-1], max_r[a]}
                   - {min_r[a][mbbn_pkg::COORD_BITS-1], min_r[a]};
      wide_sum[a]  = {max_r[a][mbbn_pkg::COORD_BITS-1], max_r[a]}
                   + {min_r[a][mbbn_pkg::COORD_BITS-1], min_r[a]};
      d[a]         = {pos_r[a][mbbn_pkg::COORD_BITS-1], pos_r[a]}
                   - {center_r[a][mbbn_pkg::COORD_BITS-1], center_r[a]};
      sat[a]       = (sum_r[a] > mbbn_pkg::ONE_FIX) ? mbbn_pkg::ONE_FIX : sum_r[a];
      rmag[a]      = sat[a][mbbn_pkg::OUT_W-1:0];
    end
    emax   = (ext_r[0] > ext_r[1]) ? ext_r[0] : ext_r[1];
    emax   = (ext_r[2] > emax) ? ext_r[2] : emax;
    rem_sh = {rem_r, quo_r[mbbn_pkg::DIVD_W-1]};
  end

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    min_nxt    = min_r;
    max_nxt    = max_r;
    center_nxt = center_r;
    scale_nxt  = scale_r;
    zero_nxt   = zero_r;
    ext_nxt    = ext_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    pos_nxt    = pos_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    sum_nxt    = sum_r;
    out_v_nxt  = out_v_r && !out_pop;
    out_nxt    = out_r;
    deg_nxt    = deg_r;
    unique case (state_r)
      mbbn_pkg::BS_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_word.cmd)
            mbbn_pkg::CMD_ACC, mbbn_pkg::CMD_FIN: begin
              q_pop = 1'b1;
              for (int a = 0; a < N; a++) begin
                if (q_word.seed) begin
                  min_nxt[a] = vin[a];
                  max_nxt[a] = vin[a];
                end else begin
                  if (vin[a] < min_r[a]) begin
                    min_nxt[a] = vin[a];
                  end
                  if (vin[a] > max_r[a]) begin
                    max_nxt[a] = vin[a];
                  end
                end
              end
              if (q_word.cmd == mbbn_pkg::CMD_FIN) begin
                state_nxt = mbbn_pkg::BS_FIN;
              end
            end
            mbbn_pkg::CMD_NORM: begin
              if (!zero_r) begin
                q_pop     = 1'b1;
                pos_nxt   = vin;
                state_nxt = mbbn_pkg::BS_DIFF;
              end else if (slot_free) begin
                q_pop     = 1'b1;
                out_v_nxt = 1'b1;
                deg_nxt   = 1'b1;
                for (int a = 0; a < N; a++) begin
                  out_nxt[a] = '0;
                end
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      mbbn_pkg::BS_FIN: begin
        for (int a = 0; a < N; a++) begin
          ext_nxt[a]    = wide_diff[a][mbbn_pkg::EXT_W-1:0];
          center_nxt[a] = wide_sum[a][mbbn_pkg::COORD_BITS:1];
        end
        state_nxt = mbbn_pkg::BS_EMAX;
      end
      mbbn_pkg::BS_EMAX: begin
        if (emax == '0) begin
          zero_nxt  = 1'b1;
          scale_nxt = '0;
          state_nxt = mbbn_pkg::BS_IDLE;
        end else begin
          div_nxt   = emax;
          rem_nxt   = '0;
          quo_nxt   = mbbn_pkg::DIVIDEND;
          dcnt_nxt  = '0;
          state_nxt = mbbn_pkg::BS_DIV;
        end
      end
      mbbn_pkg::BS_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = mbbn_pkg::EXT_W'(rem_sh - {1'b0, div_r});
          quo_nxt = {quo_r[mbbn_pkg::DIVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[mbbn_pkg::EXT_W-1:0];
          quo_nxt = {quo_r[mbbn_pkg::DIVD_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == mbbn_pkg::DCNT_W'(mbbn_pkg::DIVD_W - 1)) begin
          zero_nxt  = 1'b0;
          scale_nxt = (|quo_nxt[mbbn_pkg::DIVD_W-1:mbbn_pkg::SCALE_W]) ? '1
                      : quo_nxt[mbbn_pkg::SCALE_W-1:0];
          state_nxt = mbbn_pkg::BS_IDLE;
        end
      end
      mbbn_pkg::BS_DIFF: begin
        for (int a = 0; a < N; a++) begin
          neg_nxt[a] = d[a][mbbn_pkg::MAG_W-1];
          mag_nxt[a] = d[a][mbbn_pkg::MAG_W-1] ? -d[a] : d[a];
        end
        state_nxt = mbbn_pkg::BS_LO;
      end
      mbbn_pkg::BS_LO: begin
        lo_nxt    = mul_p;
        state_nxt = mbbn_pkg::BS_HI;
      end
      mbbn_pkg::BS_HI: begin
        hi_nxt    = mul_p;
        state_nxt = mbbn_pkg::BS_SUM;
      end
      mbbn_pkg::BS_SUM: begin
        for (int a = 0; a < N; a++) begin
          sum_nxt[a] = mbbn_pkg::SUM_W'(hi_r[a]) + mbbn_pkg::SUM_W'(lo_r[a] >> F);
        end
        state_nxt = mbbn_pkg::BS_SAT;
      end
      mbbn_pkg::BS_SAT: begin
        if (slot_free) begin
          for (int a = 0; a < N; a++) begin
            out_nxt[a] = neg_r[a] ? -rmag[a] : rmag[a];
          end
          out_v_nxt = 1'b1;
          deg_nxt   = 1'b0;
          state_nxt = mbbn_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = mbbn_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbbn_pkg::BS_IDLE;
      out_v_r <= 1'b0;
      zero_r  <= 1'b1;
      scale_r <= '0;
      for (int a = 0; a < N; a++) begin
        min_r[a]    <= '0;
        max_r[a]    <= '0;
        center_r[a] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      out_v_r  <= out_v_nxt;
      zero_r   <= zero_nxt;
      scale_r  <= scale_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      center_r <= center_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ext_r  <= ext_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    pos_r  <= pos_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    sum_r  <= sum_nxt;
    out_r  <= out_nxt;
    deg_r  <= deg_nxt;
  end

endmodule

// ===== src/mesh_bounding_box_normalizer_core.sv =====
// channel   direction  handshake          word
// in_       input      in_push / in_full  operation, pos_x/y/z, first_vertex, last_vertex
// out_      output     out_pop / out_empty  norm_x/y/z, degenerate
//
// accumulate words are taken in the back end's idle state; a last vertex then passes
// BS_FIN and BS_EMAX, then the divider (one quotient bit per cycle) unless the box is flat
// normalize words go through dequeue, difference, two partial products on one lane
// multiplier per axis, sum, saturate; a flat box answers at dequeue with a degenerate word
// rst_n is synchronous; state comes out of reset at once, no clearing pass
// a 2-word queue and a 1-word output register let input and output stall on their own
module mesh_bounding_box_normalizer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_operation,
  input  logic signed [mbbn_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [mbbn_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [mbbn_pkg::POS_W-1:0]   in_pos_z,
  input  logic                                in_first_vertex,
  input  logic                                in_last_vertex,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [mbbn_pkg::OUT_W-1:0]   out_norm_x,
  output logic signed [mbbn_pkg::OUT_W-1:0]   out_norm_y,
  output logic signed [mbbn_pkg::OUT_W-1:0]   out_norm_z,
  output logic                                out_degenerate
);

  mbbn_pkg::qstat_t q_stat;
  mbbn_pkg::vtx_t   q_wr_word;
  mbbn_pkg::vtx_t   q_rd_word;
  logic             q_push;
  logic             q_pop;

  mbbn_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .operation    (in_operation),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .pos_z        (in_pos_z),
    .first_vertex (in_first_vertex),
    .last_vertex  (in_last_vertex),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_word       (q_wr_word)
  );

  mbbn_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_word (q_wr_word),
    .pop     (q_pop),
    .rd_word (q_rd_word),
    .stat    (q_stat)
  );

  mbbn_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_word         (q_rd_word),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_norm_x     (out_norm_x),
    .out_norm_y     (out_norm_y),
    .out_norm_z     (out_norm_z),
    .out_degenerate (out_degenerate)
  );

`ifndef SYNTHESIS
  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_degenerate) |->
      (out_norm_x == '0 && out_norm_y == '0 && out_norm_z == '0))
    else $error("degenerate word with nonzero coordinates");

  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      (out_norm_x <= mbbn_pkg::ONE_OUT && out_norm_x >= -mbbn_pkg::ONE_OUT &&
       out_norm_y <= mbbn_pkg::ONE_OUT && out_norm_y >= -mbbn_pkg::ONE_OUT &&
       out_norm_z <= mbbn_pkg::ONE_OUT && out_norm_z >= -mbbn_pkg::ONE_OUT))
    else $error("normalized coordinate outside unit range");

  a_q_state : assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_stat.empty)
    else $error("queue full and empty together");

  a_q_pop : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("back end pops an empty queue");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int POS_W = mbbn_pkg::POS_W;
  localparam int OUT_W = mbbn_pkg::OUT_W;
  localparam int FRAC_BITS = mbbn_pkg::FRAC_BITS;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_NORM = 1'b1;

  localparam logic signed [POS_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic [OUT_W-1:0] UNIT_OUT = OUT_W'(1) << FRAC_BITS;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } point_t;

  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic degen;
  } norm_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_operation = 1'b0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic in_first_vertex = 1'b0;
  logic in_last_vertex = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [OUT_W-1:0] out_norm_x;
  logic signed [OUT_W-1:0] out_norm_y;
  logic signed [OUT_W-1:0] out_norm_z;
  logic out_degenerate;

  // box tracking copy
  longint box_lo[3] = '{0, 0, 0};
  longint box_hi[3] = '{0, 0, 0};
  longint box_center[3] = '{0, 0, 0};
  logic [31:0] box_scale = '0;
  bit flat_mesh = 1'b1;

  norm_word_t expected_words[$];
  norm_word_t head;
  int errors = 0;
  int words_checked = 0;
  int vertices_sent = 0;
  int idle_pct = 9;
  int cycle_count = 0;

  mesh_bounding_box_normalizer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_first_vertex(in_first_vertex),
    .in_last_vertex (in_last_vertex),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_norm_x     (out_norm_x),
    .out_norm_y     (out_norm_y),
    .out_norm_z     (out_norm_z),
    .out_degenerate (out_degenerate)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic point_t pt(input logic signed [POS_W-1:0] x,
                                input logic signed [POS_W-1:0] y,
                                input logic signed [POS_W-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic logic [OUT_W-1:0] scaled_axis(input longint v, input longint c);
    longint d;
    longint unsigned mag;
    logic [127:0] prod;
    logic [127:0] mag_q;
    logic [OUT_W-1:0] res;
    d = v - c;
    mag = (d < 0) ? longint'(-d) : d;
    prod = {64'd0, mag} * {96'd0, box_scale};
    if (prod[127:64] != '0) begin
      mag_q = 128'(UNIT_OUT);
    end else begin
      mag_q = prod >> FRAC_BITS;
      if (mag_q > 128'(UNIT_OUT)) mag_q = 128'(UNIT_OUT);
    end
    res = mag_q[OUT_W-1:0];
    if (d < 0) res = -res;
    return res;
  endfunction

  function automatic void predict_vertex(input logic op, input point_t p,
                                         input logic first, input logic last);
    longint v[3];
    longint unsigned ext;
    longint unsigned span_a;
    logic [63:0] quot;
    norm_word_t w;
    v[0] = longint'($signed(p.x));
    v[1] = longint'($signed(p.y));
    v[2] = longint'($signed(p.z));
    if (op == OP_ACCUM) begin
      for (int a = 0; a < 3; a++) begin
        if (first) begin
          box_lo[a] = v[a];
          box_hi[a] = v[a];
        end else begin
          if (v[a] < box_lo[a]) box_lo[a] = v[a];
          if (v[a] > box_hi[a]) box_hi[a] = v[a];
        end
      end
      if (last) begin
        ext = 0;
        for (int a = 0; a < 3; a++) begin
          span_a = box_hi[a] - box_lo[a];
          if (span_a > ext) ext = span_a;
          box_center[a] = (box_hi[a] + box_lo[a]) >>> 1;
        end
        if (ext == 0) begin
          flat_mesh = 1'b1;
          box_scale = '0;
        end else begin
          quot = (64'd1 << (2 * FRAC_BITS + 1)) / ext;
          flat_mesh = 1'b0;
          box_scale = (quot > 64'hffff_ffff) ? 32'hffff_ffff : quot[31:0];
        end
      end
    end else begin
      if (flat_mesh) begin
        w.x = '0;
        w.y = '0;
        w.z = '0;
        w.degen = 1'b1;
      end else begin
        w.x = scaled_axis(v[0], box_center[0]);
        w.y = scaled_axis(v[1], box_center[1]);
        w.z = scaled_axis(v[2], box_center[2]);
        w.degen = 1'b0;
      end
      expected_words = {expected_words, w};
    end
  endfunction

  task automatic send_vertex(input logic op, input point_t p,
                             input logic first, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_operation <= op;
    in_pos_x <= p.x;
    in_pos_y <= p.y;
    in_pos_z <= p.z;
    in_first_vertex <= first;
    in_last_vertex <= last;
    do @(posedge clk); while (in_full);
    predict_vertex(op, p, first, last);
    vertices_sent++;
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    if (errors < 40)
      $display("mismatch %s on word %0d: got %h want %h", what, words_checked, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_norm_x, '0);
        end else begin
          head = expected_words.pop_front();
          if (out_norm_x !== head.x) report_mismatch("norm_x", out_norm_x, head.x);
          if (out_norm_y !== head.y) report_mismatch("norm_y", out_norm_y, head.y);
          if (out_norm_z !== head.z) report_mismatch("norm_z", out_norm_z, head.z);
          if (out_degenerate !== head.degen)
            report_mismatch("degenerate", OUT_W'(out_degenerate), OUT_W'(head.degen));
        end
        words_checked++;
      end
      out_pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic point_t mesh_point(input logic [31:0] base[3], input int span[3]);
    logic [31:0] c[3];
    for (int a = 0; a < 3; a++)
      c[a] = base[a] + ($urandom & ((32'd1 << span[a]) - 32'd1));
    return pt(c[0], c[1], c[2]);
  endfunction

  task automatic run_mesh(input bit seed_it, input bit close_it);
    int nv;
    int span[3];
    logic [31:0] base[3];
    point_t pts[$];
    point_t p;
    nv = $urandom_range(1, 12);
    for (int a = 0; a < 3; a++) begin
      base[a] = $urandom;
      span[a] = ($urandom_range(7) == 0) ? 0 : $urandom_range(31);
    end
    if ($urandom_range(11) == 0) span = '{0, 0, 0};
    for (int i = 0; i < nv; i++) begin
      p = mesh_point(base, span);
      pts = {pts, p};
      send_vertex(OP_ACCUM, p, seed_it && i == 0, close_it && i == nv - 1);
    end
    for (int i = 0; i < nv; i++) begin
      p = pts[$urandom_range(nv - 1)];
      send_vertex(OP_NORM, p, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    repeat ($urandom_range(2))
      send_vertex(OP_NORM, pt($urandom, $urandom, $urandom), 1'b0, 1'b0);
  endtask

  task automatic run_mesh_stream(input int count);
    int stop_at;
    stop_at = vertices_sent + count;
    while (vertices_sent < stop_at) begin
      run_mesh($urandom_range(9) != 0, $urandom_range(9) != 0);
      if ($urandom_range(9) == 0) drain_results();
    end
  endtask

  task automatic test_before_finalize();
    send_vertex(OP_NORM, pt(0, 0, 0), 1'b1, 1'b1);
    send_vertex(OP_NORM, pt(COORD_MIN, COORD_MAX, -1), 1'b0, 1'b1);
  endtask

  task automatic test_unseeded_from_reset();
    // grows the zero box left by reset
    send_vertex(OP_ACCUM, pt(32'sd5 <<< 16, -(32'sd3 <<< 16), 0), 1'b0, 1'b1);
    send_vertex(OP_NORM, pt(32'sd5 <<< 16, -(32'sd3 <<< 16), 0), 1'b0, 1'b0);
    send_vertex(OP_NORM, pt(0, 0, 0), 1'b1, 1'b0);
    send_vertex(OP_NORM, pt(COORD_MAX, COORD_MIN, 32'sd1), 1'b0, 1'b0);
  endtask

  task automatic test_extremes();
    send_vertex(OP_ACCUM, pt(COORD_MIN, COORD_MIN, COORD_MAX), 1'b1, 1'b0);
    send_vertex(OP_ACCUM, pt(COORD_MAX, COORD_MAX, COORD_MIN), 1'b0, 1'b1);
    send_vertex(OP_NORM, pt(COORD_MIN, COORD_MAX, 0), 1'b0, 1'b0);
    send_vertex(OP_NORM, pt(COORD_MAX, COORD_MIN, -1), 1'b0, 1'b0);
    send_vertex(OP_NORM, pt(0, 0, 0), 1'b0, 1'b0);
    // unit extent, scale clamps to its top value
    send_vertex(OP_ACCUM, pt(0, 0, 0), 1'b1, 1'b0);
    send_vertex(OP_ACCUM, pt(1, 0, 0), 1'b0, 1'b1);
    send_vertex(OP_NORM, pt(1, 0, 0), 1'b0, 1'b0);
    send_vertex(OP_NORM, pt(0, 0, 0), 1'b0, 1'b0);
    send_vertex(OP_NORM, pt(COORD_MAX, COORD_MIN, 2), 1'b0, 1'b0);
  endtask

  task automatic test_seed_and_finalize_together();
    send_vertex(OP_ACCUM, pt(7, 8, 9), 1'b1, 1'b1);
    send_vertex(OP_NORM, pt(7, 8, 9), 1'b0, 1'b0);
    send_vertex(OP_NORM, pt(COORD_MIN, 0, COORD_MAX), 1'b0, 1'b0);
  endtask

  task automatic test_random_meshes();
    idle_pct = 9;
    run_mesh(1'($urandom_range(1)), 1'b1);
    drain_results();
    run_mesh_stream(300);
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    run_mesh_stream(180);
    idle_pct = 9;
  endtask

  task automatic test_noise();
    repeat (60)
      send_vertex(1'($urandom_range(1)), pt($urandom, $urandom, $urandom),
                  1'($urandom_range(1)), $urandom_range(3) == 0);
    run_mesh_stream(120);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_finalize();
    test_unseeded_from_reset();
    test_extremes();
    test_seed_and_finalize_together();
    test_random_meshes();
    test_back_to_back();
    test_noise();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
